### hdl/isbrs_pkg.sv
// Shared types, codes and sizes for the sensor burst-read sequencer.
package isbrs_pkg;

  localparam int unsigned BURST_BYTES = 14;
  localparam int unsigned NUM_WORDS   = 7;
  localparam int unsigned WORD_BYTES  = 2 * NUM_WORDS;
  localparam int unsigned IDX_W       = $clog2(BURST_BYTES);
  localparam int unsigned CNT_W       = $clog2(BURST_BYTES + 1);

  // Commands to the bus master
  localparam logic [2:0] CMD_NONE    = 3'd0;
  localparam logic [2:0] CMD_START   = 3'd1;
  localparam logic [2:0] CMD_ADDR    = 3'd2;
  localparam logic [2:0] CMD_DATA    = 3'd3;
  localparam logic [2:0] CMD_ACK_ON  = 3'd4;
  localparam logic [2:0] CMD_STOP    = 3'd5;
  localparam logic [2:0] CMD_RESTART = 3'd6;

  // Bus events reported by the bus master
  localparam logic [2:0] EV_START    = 3'd1;
  localparam logic [2:0] EV_TX_ACK   = 3'd2;
  localparam logic [2:0] EV_SENT     = 3'd3;
  localparam logic [2:0] EV_RX_ACK   = 3'd4;
  localparam logic [2:0] EV_RECEIVED = 3'd5;

  // Configuration register indexes
  localparam logic REG_DEVICE_ADDRESS = 1'b0;
  localparam logic REG_FIRST_REGISTER = 1'b1;

  localparam logic [6:0] DEVICE_ADDRESS_RST = 7'd104;
  localparam logic [7:0] FIRST_REGISTER_RST = 8'd59;

  typedef enum logic [7:0] {
    PH_IDLE       = 8'b0000_0001,
    PH_START_WAIT = 8'b0000_0010,
    PH_WADDR_WAIT = 8'b0000_0100,
    PH_REG_WAIT   = 8'b0000_1000,
    PH_RSTART_WAIT= 8'b0001_0000,
    PH_RADDR_WAIT = 8'b0010_0000,
    PH_COLLECT    = 8'b0100_0000,
    PH_FINAL      = 8'b1000_0000
  } phase_e;

  typedef struct packed {
    logic       bus_busy;
    logic [2:0] bus_event;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic [2:0]         command;
    logic [7:0]         command_byte;
    logic               done_res;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] temperature_raw;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
  } out_t;

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [7:0]       wr_data;
  } store_wr_t;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] command_byte;
    logic       done_res;
  } seq_res_t;

  typedef logic [NUM_WORDS-1:0][15:0] words_t;

endpackage

### hdl/isbrs_seq.sv
// Phase sequencer: next command, byte count and store writes for each poll.
module isbrs_seq import isbrs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  in_t        poll_i,
  input  logic [6:0] device_address_i,
  input  logic [7:0] first_register_i,
  output seq_res_t   res_o,
  output store_wr_t  store_wr_o
);

  localparam logic [CNT_W-1:0] BURST_CNT = CNT_W'(BURST_BYTES);
  localparam logic [CNT_W-1:0] LAST_CNT  = CNT_W'(BURST_BYTES - 1);

  phase_e           phase_q, phase_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] cnt_inc;
  logic             cnt_in_range;

  assign cnt_in_range = (cnt_q < BURST_CNT);
  assign cnt_inc      = cnt_in_range ? cnt_q + CNT_W'(1) : cnt_q;

  always_comb begin
    phase_d    = phase_q;
    cnt_d      = cnt_q;
    res_o      = '0;
    store_wr_o = '0;
    store_wr_o.wr_idx  = cnt_q[IDX_W-1:0];
    store_wr_o.wr_data = poll_i.rx_byte;
    unique case (phase_q)
      PH_IDLE: begin
        if (!poll_i.bus_busy) begin
          phase_d       = PH_START_WAIT;
          res_o.command = CMD_START;
        end
      end
      PH_START_WAIT: begin
        if (poll_i.bus_event == EV_START) begin
          phase_d            = PH_WADDR_WAIT;
          res_o.command      = CMD_ADDR;
          res_o.command_byte = {device_address_i, 1'b0};
        end
      end
      PH_WADDR_WAIT: begin
        if (poll_i.bus_event == EV_TX_ACK) begin
          phase_d            = PH_REG_WAIT;
          res_o.command      = CMD_DATA;
          res_o.command_byte = first_register_i;
        end
      end
      PH_REG_WAIT: begin
        if (poll_i.bus_event == EV_SENT) begin
          phase_d       = PH_RSTART_WAIT;
          res_o.command = CMD_RESTART;
        end
      end
      PH_RSTART_WAIT: begin
        if (poll_i.bus_event == EV_START) begin
          phase_d            = PH_RADDR_WAIT;
          res_o.command      = CMD_ADDR;
          res_o.command_byte = {device_address_i, 1'b1};
        end
      end
      PH_RADDR_WAIT: begin
        if (poll_i.bus_event == EV_RX_ACK) begin
          phase_d       = PH_COLLECT;
          res_o.command = CMD_ACK_ON;
          cnt_d         = '0;
        end
      end
      PH_COLLECT: begin
        if (poll_i.bus_event == EV_RECEIVED) begin
          store_wr_o.wr_en = step_i & cnt_in_range;
          cnt_d            = cnt_inc;
          // stop goes out with the second-last byte
          if (cnt_inc >= LAST_CNT) begin
            phase_d       = PH_FINAL;
            res_o.command = CMD_STOP;
          end
        end
      end
      PH_FINAL: begin
        if (poll_i.bus_event == EV_RECEIVED) begin
          store_wr_o.wr_en = step_i & cnt_in_range;
          phase_d          = PH_IDLE;
          res_o.done_res   = 1'b1;
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

### hdl/isbrs_store.sv
// Received-byte store and big-endian word packing with write bypass.
module isbrs_store import isbrs_pkg::*; (
  input  logic      clk_i,
  input  store_wr_t store_wr_i,
  output words_t    words_o
);

  logic [BURST_BYTES-1:0][7:0] store_q;
  logic [WORD_BYTES-1:0][7:0]  rd_byte;

  always_ff @(posedge clk_i) begin
    if (store_wr_i.wr_en) begin
      store_q[store_wr_i.wr_idx] <= store_wr_i.wr_data;
    end
  end

  // The byte being written this cycle is forwarded so the final word is complete
  for (genvar j = 0; j < WORD_BYTES; j++) begin : g_rd
    if (j < BURST_BYTES) begin : g_in
      assign rd_byte[j] = (store_wr_i.wr_en && store_wr_i.wr_idx == IDX_W'(j)) ?
                          store_wr_i.wr_data : store_q[j];
    end else begin : g_out
      assign rd_byte[j] = 8'h00;
    end
  end

  for (genvar k = 0; k < NUM_WORDS; k++) begin : g_word
    assign words_o[k] = {rd_byte[2*k], rd_byte[2*k+1]};
  end

endmodule

### hdl/i2c_sensor_burst_read_sequencer.sv
// Top level: configuration registers, poll handshake and result register.
//
//  channel  direction  handshake                  payload
//  in       sink       in_valid_i / in_ready_o    in_data_i   (in_t)
//  out      source     out_valid_o / out_ready_i  out_data_o  (out_t)
//  cfg      sink       cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// Each poll produces one command, registered in the cycle after acceptance;
// one poll per cycle is sustained while out_ready_i is high, set by the single result register.
// in_ready_o drops only while a result is held and out_ready_i is low.
// Reset puts the sequencer idle with a zero byte count and the address and
// register back to 104 and 59; the byte store is not cleared.
module i2c_sensor_burst_read_sequencer import isbrs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_t        in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_t       out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  logic       accept;
  logic       out_valid_q;
  out_t       out_q, out_d;
  logic [6:0] dev_addr_q;
  logic [7:0] first_reg_q;
  seq_res_t   seq_res;
  store_wr_t  store_wr;
  words_t     words;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q  <= DEVICE_ADDRESS_RST;
      first_reg_q <= FIRST_REGISTER_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_DEVICE_ADDRESS: dev_addr_q  <= cfg_data_i[6:0];
        REG_FIRST_REGISTER: first_reg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  isbrs_seq u_seq (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (accept),
    .poll_i           (in_data_i),
    .device_address_i (dev_addr_q),
    .first_register_i (first_reg_q),
    .res_o            (seq_res),
    .store_wr_o       (store_wr)
  );

  isbrs_store u_store (
    .clk_i      (clk_i),
    .store_wr_i (store_wr),
    .words_o    (words)
  );

  always_comb begin
    out_d              = '0;
    out_d.command      = seq_res.command;
    out_d.command_byte = seq_res.command_byte;
    out_d.done_res     = seq_res.done_res;
    if (seq_res.done_res) begin
      out_d.accel_x         = words[0];
      out_d.accel_y         = words[1];
      out_d.accel_z         = words[2];
      out_d.temperature_raw = words[3];
      out_d.gyro_x          = words[4];
      out_d.gyro_y          = words[5];
      out_d.gyro_z          = words[6];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted poll produced no result");

  a_held_result_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !in_ready_o)
    else $error("poll accepted while result stalled");

  a_done_no_command: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.done_res) |-> (out_q.command == CMD_NONE))
    else $error("command issued alongside done");

  a_words_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.done_res) |->
      (out_q.accel_x == 16'sd0 && out_q.gyro_z == 16'sd0))
    else $error("words not zero without done");

endmodule

### bench/tb.sv
// Self-checking bench for the sensor burst-read sequencer: polls in, commands out.
`timescale 1ns / 1ps

module tb import isbrs_pkg::*;;

  // Event codes with no name in the package
  localparam logic [2:0] EV_NOTHING   = 3'd0;
  localparam logic [2:0] EV_UNUSED_LO = 3'd6;
  localparam logic [2:0] EV_UNUSED_HI = 3'd7;
  localparam int         MAX_GAP      = 11;
  localparam int         STALL_LIMIT  = 1000;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  in_t        in_data_i;
  logic       out_valid_o;
  logic       out_ready_i;
  out_t       out_data_o;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic       cfg_index_i;
  logic [7:0] cfg_data_i;

  i2c_sensor_burst_read_sequencer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predicted sequencer state and registers
  phase_e           seq_phase;
  logic [CNT_W-1:0] rx_count;
  logic [7:0]       rx_store [BURST_BYTES];
  logic [6:0]       dev_addr;
  logic [7:0]       start_reg;

  out_t pending_cmds [$];
  int   errors;
  int   polls_sent;
  int   cmds_checked;
  int   bursts_checked;
  int   settings_applied;
  int   poll_gap;
  int   idle_cycles;
  bit   no_idle;

  function automatic int draw_gap();
    if (no_idle) return 0;
    return $urandom_range(0, MAX_GAP);
  endfunction

  function automatic logic [7:0] stored_byte(input int unsigned idx);
    if (idx < BURST_BYTES) return rx_store[idx];
    return 8'h00;
  endfunction

  function automatic in_t make_poll(input logic busy, input logic [2:0] ev,
                                    input logic [7:0] rx);
    in_t p;
    p.bus_busy  = busy;
    p.bus_event = ev;
    p.rx_byte   = rx;
    return p;
  endfunction

  function automatic out_t predict_poll(input in_t poll);
    out_t res;
    res = '0;
    case (seq_phase)
      PH_IDLE: if (!poll.bus_busy) begin
        seq_phase   = PH_START_WAIT;
        res.command = CMD_START;
      end
      PH_START_WAIT: if (poll.bus_event == EV_START) begin
        seq_phase        = PH_WADDR_WAIT;
        res.command      = CMD_ADDR;
        res.command_byte = {dev_addr, 1'b0};
      end
      PH_WADDR_WAIT: if (poll.bus_event == EV_TX_ACK) begin
        seq_phase        = PH_REG_WAIT;
        res.command      = CMD_DATA;
        res.command_byte = start_reg;
      end
      PH_REG_WAIT: if (poll.bus_event == EV_SENT) begin
        seq_phase   = PH_RSTART_WAIT;
        res.command = CMD_RESTART;
      end
      PH_RSTART_WAIT: if (poll.bus_event == EV_START) begin
        seq_phase        = PH_RADDR_WAIT;
        res.command      = CMD_ADDR;
        res.command_byte = {dev_addr, 1'b1};
      end
      PH_RADDR_WAIT: if (poll.bus_event == EV_RX_ACK) begin
        seq_phase   = PH_COLLECT;
        res.command = CMD_ACK_ON;
        rx_count    = '0;
      end
      PH_COLLECT: if (poll.bus_event == EV_RECEIVED) begin
        if (rx_count < BURST_BYTES) begin
          rx_store[rx_count] = poll.rx_byte;
          rx_count++;
        end
        // stop goes out with the second-to-last byte
        if (rx_count >= BURST_BYTES - 1) begin
          res.command = CMD_STOP;
          seq_phase   = PH_FINAL;
        end
      end
      default: if (poll.bus_event == EV_RECEIVED) begin
        if (rx_count < BURST_BYTES) rx_store[rx_count] = poll.rx_byte;
        seq_phase           = PH_IDLE;
        res.done_res        = 1'b1;
        res.accel_x         = {stored_byte(0),  stored_byte(1)};
        res.accel_y         = {stored_byte(2),  stored_byte(3)};
        res.accel_z         = {stored_byte(4),  stored_byte(5)};
        res.temperature_raw = {stored_byte(6),  stored_byte(7)};
        res.gyro_x          = {stored_byte(8),  stored_byte(9)};
        res.gyro_y          = {stored_byte(10), stored_byte(11)};
        res.gyro_z          = {stored_byte(12), stored_byte(13)};
      end
    endcase
    return res;
  endfunction

  task automatic send_poll(input in_t item);
    repeat (poll_gap) @(posedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    polls_sent++;
    pending_cmds.push_back(predict_poll(item));
    // valid stays up only when the next transaction follows at once
    poll_gap = draw_gap();
    if (poll_gap != 0) in_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    if (poll_gap == 0) in_valid_i <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic configure(input logic [7:0] addr_val, input logic [7:0] reg_val);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= REG_DEVICE_ADDRESS;
    cfg_data_i  <= addr_val;
    do @(posedge clk_i); while (!cfg_ready_o);
    dev_addr = addr_val[6:0];
    cfg_index_i <= REG_FIRST_REGISTER;
    cfg_data_i  <= reg_val;
    do @(posedge clk_i); while (!cfg_ready_o);
    start_reg = reg_val;
    cfg_valid_i <= 1'b0;
    settings_applied++;
  endtask

  // The event the sequencer waits for, or random noise in noise_pct percent of polls;
  // always stops with the sequencer back in idle.
  task automatic run_polls(input int awaited_target, input int noise_pct);
    int  awaited_sent;
    in_t item;
    awaited_sent = 0;
    while (awaited_sent < awaited_target || seq_phase != PH_IDLE) begin
      item = make_poll(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                       8'($urandom_range(0, 255)));
      if ($urandom_range(0, 99) >= noise_pct) begin
        awaited_sent++;
        case (seq_phase)
          PH_IDLE:                       item.bus_busy  = 1'b0;
          PH_START_WAIT, PH_RSTART_WAIT: item.bus_event = EV_START;
          PH_WADDR_WAIT:                 item.bus_event = EV_TX_ACK;
          PH_REG_WAIT:                   item.bus_event = EV_SENT;
          PH_RADDR_WAIT:                 item.bus_event = EV_RX_ACK;
          default:                       item.bus_event = EV_RECEIVED;
        endcase
      end
      send_poll(item);
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] exp_val,
                             input logic [15:0] act_val);
    if (exp_val !== act_val) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
    end
  endtask

  task automatic check_result(input out_t got);
    out_t exp;
    if (pending_cmds.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, expected none, actual %h", $time, got);
      return;
    end
    exp = pending_cmds.pop_front();
    cmds_checked++;
    if (exp.done_res) bursts_checked++;
    check_field("command",         exp.command,         got.command);
    check_field("command_byte",    exp.command_byte,    got.command_byte);
    check_field("done_res",        exp.done_res,        got.done_res);
    check_field("accel_x",         exp.accel_x,         got.accel_x);
    check_field("accel_y",         exp.accel_y,         got.accel_y);
    check_field("accel_z",         exp.accel_z,         got.accel_z);
    check_field("temperature_raw", exp.temperature_raw, got.temperature_raw);
    check_field("gyro_x",          exp.gyro_x,          got.gyro_x);
    check_field("gyro_y",          exp.gyro_y,          got.gyro_y);
    check_field("gyro_z",          exp.gyro_z,          got.gyro_z);
  endtask

  // Reset config, busy blocking, ignored events and bytes, word extremes
  task automatic test_directed_burst();
    logic [7:0] corner_bytes [14] = '{8'h80, 8'h00, 8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'h00,
                                      8'h00, 8'h00, 8'h01, 8'h80, 8'h01, 8'h5A, 8'hA5};
    send_poll(make_poll(1'b1, EV_START,     8'hFF));
    send_poll(make_poll(1'b0, EV_NOTHING,   8'h00));
    send_poll(make_poll(1'b0, EV_RECEIVED,  8'hAA));
    send_poll(make_poll(1'b1, EV_START,     8'h00));
    send_poll(make_poll(1'b0, EV_UNUSED_HI, 8'h00));
    send_poll(make_poll(1'b0, EV_TX_ACK,    8'h00));
    send_poll(make_poll(1'b0, EV_UNUSED_LO, 8'h00));
    send_poll(make_poll(1'b0, EV_SENT,      8'h00));
    send_poll(make_poll(1'b0, EV_START,     8'h00));
    send_poll(make_poll(1'b0, EV_RX_ACK,    8'h00));
    send_poll(make_poll(1'b0, EV_NOTHING,   8'h55));
    foreach (corner_bytes[i]) send_poll(make_poll(1'b0, EV_RECEIVED, corner_bytes[i]));
  endtask

  task automatic test_config_extremes();
    configure(8'h00, 8'h00);
    run_polls(20, 0);
    configure(8'hFF, 8'hFF);
    run_polls(20, 0);
    configure(8'h7F, 8'h80);
    run_polls(20, 10);
    // top bit of the address write is dropped
    configure(8'h80, 8'h7F);
    run_polls(20, 10);
  endtask

  task automatic test_noise();
    run_polls(15, 90);
  endtask

  task automatic test_random_bursts();
    for (int chunk = 0; chunk < 6; chunk++) begin
      configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      no_idle = (chunk == 2);
      run_polls(55, 15);
      wait_drained();
      run_polls(55, 15);
    end
    no_idle = 1'b0;
  endtask

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: timeout, no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : result_checker
    int stall;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = draw_gap();
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      check_result(out_data_o);
    end
  end

  initial begin
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    in_data_i        = '0;
    out_ready_i      = 1'b0;
    cfg_valid_i      = 1'b0;
    cfg_index_i      = REG_DEVICE_ADDRESS;
    cfg_data_i       = '0;
    seq_phase        = PH_IDLE;
    rx_count         = '0;
    dev_addr         = DEVICE_ADDRESS_RST;
    start_reg        = FIRST_REGISTER_RST;
    foreach (rx_store[i]) rx_store[i] = 8'h00;
    errors           = 0;
    polls_sent       = 0;
    cmds_checked     = 0;
    bursts_checked   = 0;
    settings_applied = 0;
    poll_gap         = 0;
    idle_cycles      = 0;
    no_idle          = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_burst();
    test_config_extremes();
    test_noise();
    test_random_bursts();

    wait_drained();
    repeat (4) @(posedge clk_i);
    $display("Sent %0d polls, checked %0d commands, %0d of them completed bursts.",
             polls_sent, cmds_checked, bursts_checked);
    $display("Used %0d register settings beyond reset, zero and all-ones included.",
             settings_applied);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
